// File: hw/rtl/cubemap_direction_face_select_top_defines.svh
// Assertion macros for the cube-map face select block.
// Used by cubemap_direction_face_select_top; needs nothing else.
`ifndef CUBEMAP_DIRECTION_FACE_SELECT_TOP_DEFINES_SVH
`define CUBEMAP_DIRECTION_FACE_SELECT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDFS_ASSERT_NOW(name, clock, resetn, pre, post, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CDFS_ASSERT_NEXT(name, clock, resetn, pre, post, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: hw/rtl/cdfs_pkg.sv
// Shared types and constants for the cube-map face select block.
// No dependencies; imported by cubemap_direction_face_select_top.
package cdfs_pkg;

    localparam int DIR_FRAC_BITS_DEF = 14;

    localparam int DIR_W   = 16;   // one direction component
    localparam int RCP_W   = 32;   // reciprocal clip w, Q16.16
    localparam int BARY_W  = 16;   // barycentric weight, Q1.15
    localparam int COORD_W = 16;
    localparam int FACE_W  = 3;

    localparam int WGT_W   = BARY_W + RCP_W;   // raw weight product
    localparam int SUM_W   = WGT_W + 2;        // sum of three weights
    localparam int NORM_W  = 40;               // normalized sum stays below 2^NORM_W
    localparam int EXTRA_W = SUM_W - NORM_W;
    localparam int SHIFT_W = 4;

    localparam int MULA_W  = DIR_W + 1;
    localparam int MULB_W  = NORM_W;
    localparam int PROD_W  = MULA_W + MULB_W - 1;
    localparam int NUM_W   = PROD_W + 1;
    localparam int D_W     = DIR_W + 1;        // interpolated component, -2^15..2^15

    localparam int DND_W   = RCP_W + 1;        // reciprocal dividend 2^32
    localparam int QUO_W   = RCP_W + 1;
    localparam int CNT_W   = 6;
    localparam int RECIP_STEPS = RCP_W + 1;
    localparam int QUOT_STEPS  = 16;

    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_FRAGMENT = 1'b1;

    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDIV,
        ST_WMUL,
        ST_NORM,
        ST_RESUM,
        ST_DMUL,
        ST_FDIV,
        ST_FACE
    } state_t;

endpackage

// File: hw/rtl/cubemap_direction_face_select_top.sv
// Cube-map face select: perspective-correct direction interpolation and face pick.
// Depends on cdfs_pkg and cubemap_direction_face_select_top_defines.svh.
//
// Usage:
//   One request channel (in_valid/in_ready) carries either a vertex load
//   (req_type 0) or a fragment (req_type 1). A vertex load stores the
//   direction and 1/clip_w of one of three vertices and gives no result;
//   a load to slot 3 is dropped. A fragment gives one result on the
//   out_valid/out_ready channel: face, u_coord, v_coord, degenerate.
//   Vertex load: after acceptance the shared divider steps out 1/w; then
//   the next request can be taken.
//   Fragment: after acceptance, 3 weight products, normalize and re-sum,
//   then per component 3 products and 16 divider steps, then the face pick;
//   a fragment whose weighted sum is zero skips from normalize to the face pick.
//   One request is in flight at a time; the shared 17x40 multiplier and the
//   one-bit-per-cycle divider set the pace.
//   The result sits in an output register; a new request is taken while it
//   waits. If the receiver stalls, the next fragment waits at its last
//   step until the output register frees up.
//   Reset clears all vertex slots to zero and empties the output register.
`include "cubemap_direction_face_select_top_defines.svh"

module cubemap_direction_face_select_top
    import cdfs_pkg::*;
#(
    parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      req_type,
    input  logic [1:0]                vertex_slot,
    input  logic signed [DIR_W-1:0]   dir_x,
    input  logic signed [DIR_W-1:0]   dir_y,
    input  logic signed [DIR_W-1:0]   dir_z,
    input  logic [RCP_W-1:0]          clip_w,
    input  logic [BARY_W-1:0]         bary_0,
    input  logic [BARY_W-1:0]         bary_1,
    input  logic [BARY_W-1:0]         bary_2,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [FACE_W-1:0]         face,
    output logic [COORD_W-1:0]        u_coord,
    output logic [COORD_W-1:0]        v_coord,
    output logic                      degenerate
);

    localparam int TB = ((DIR_FRAC_BITS > 15) ? DIR_FRAC_BITS : 15) + 2;
    localparam logic [TB:0] ONE_T =
        {{(TB - DIR_FRAC_BITS){1'b0}}, 1'b1, {DIR_FRAC_BITS{1'b0}}};
    localparam logic [DND_W-1:0] RECIP_DND = {1'b1, {RCP_W{1'b0}}};

    // (c + 1.0) / 2 as Q0.16, clamped
    function automatic logic [COORD_W-1:0] to_coord(input logic signed [D_W-1:0] c);
        logic signed [TB:0] t;
        logic [TB+14:0]     r;
        t = (TB + 1)'(c) + $signed(ONE_T);
        r = {t[TB-1:0], 15'b0} >> DIR_FRAC_BITS;
        if (t[TB] || (t == '0))
            to_coord = '0;
        else if (|r[TB+14:COORD_W])
            to_coord = '1;
        else
            to_coord = r[COORD_W-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [1:0]              ld_slot_reg, ld_slot_next;
    logic [3*DIR_W-1:0]      ld_dir_reg, ld_dir_next;
    logic [BARY_W-1:0]       bary_reg [3];
    logic [BARY_W-1:0]       bary_next [3];
    logic [3*DIR_W-1:0]      vdir_reg [3];
    logic [3*DIR_W-1:0]      vdir_next [3];
    logic [RCP_W-1:0]        vrcp_reg [3];
    logic [RCP_W-1:0]        vrcp_next [3];
    logic [WGT_W-1:0]        w_reg [3];
    logic [WGT_W-1:0]        w_next [3];
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [NUM_W-1:0] num_reg, num_next;
    logic                    neg_reg, neg_next;
    logic [1:0]              idx_reg, idx_next;
    logic [1:0]              comp_reg, comp_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [NORM_W-1:0]       rem_reg, rem_next;
    logic [NORM_W-1:0]       dvs_reg, dvs_next;
    logic [DND_W-1:0]        dnd_reg, dnd_next;
    logic [QUO_W-1:0]        quo_reg, quo_next;
    logic signed [D_W-1:0]   d_reg [3];
    logic signed [D_W-1:0]   d_next [3];
    logic                    degen_reg, degen_next;
    logic                    out_valid_reg, out_valid_next;
    logic [FACE_W-1:0]       face_reg, face_next;
    logic [COORD_W-1:0]      u_reg, u_next;
    logic [COORD_W-1:0]      v_reg, v_next;
    logic                    odeg_reg, odeg_next;

    // shared multiplier operands
    logic signed [MULA_W-1:0] mul_a;
    logic [MULB_W-1:0]        mul_b;
    logic signed [NUM_W-1:0]  mul_full;
    logic [1:0]               idx_rd;
    logic [1:0]               idx_prev;

    // shared divider step
    logic [NORM_W:0]          trial;
    logic                     ge;
    logic [NORM_W-1:0]        step_rem;
    logic [QUO_W-1:0]         step_quo;

    logic signed [NUM_W-1:0]  num_sum;
    logic [NUM_W-1:0]         num_mag;
    logic [SHIFT_W-1:0]       norm_k;
    logic [QUOT_STEPS-1:0]    q_val;

    logic                     out_load;
    logic [FACE_W-1:0]        sel_face;
    logic signed [D_W-1:0]    sel_u;
    logic signed [D_W-1:0]    sel_v;
    logic [D_W-1:0]           ax, ay, az;

    assign idx_rd   = (idx_reg == 2'd3) ? 2'd0 : idx_reg;
    assign idx_prev = idx_reg - 2'd1;

    always_comb
    begin
        trial    = {rem_reg, dnd_reg[DND_W-1]};
        ge       = (trial >= {1'b0, dvs_reg});
        step_rem = ge ? NORM_W'(trial - {1'b0, dvs_reg}) : trial[NORM_W-1:0];
        step_quo = {quo_reg[QUO_W-2:0], ge};
    end

    assign mul_full  = mul_a * $signed({1'b0, mul_b});
    assign prod_next = mul_full[PROD_W-1:0];
    assign num_sum   = num_reg + NUM_W'(prod_reg);
    assign num_mag   = num_sum[NUM_W-1] ? NUM_W'(-num_sum) : num_sum;
    assign q_val     = step_quo[QUOT_STEPS-1:0];

    always_comb
    begin
        norm_k = '0;
        for (int j = 0; j < EXTRA_W; j++)
        begin
            if (sum_reg[NORM_W + j])
                norm_k = SHIFT_W'(j + 1);
        end
    end

    // face pick: strictly largest magnitude wins, ties fall back to +y mapping
    always_comb
    begin
        ax = d_reg[0][D_W-1] ? D_W'(-d_reg[0]) : d_reg[0];
        ay = d_reg[1][D_W-1] ? D_W'(-d_reg[1]) : d_reg[1];
        az = d_reg[2][D_W-1] ? D_W'(-d_reg[2]) : d_reg[2];
        sel_face = FACE_POS_Y;
        sel_u    = d_reg[0];
        sel_v    = d_reg[2];
        if ((ay > ax) && (ay > az))
        begin
            sel_face = (d_reg[1] > 0) ? FACE_POS_Y : FACE_NEG_Y;
            sel_u    = d_reg[0];
            sel_v    = (d_reg[1] > 0) ? d_reg[2] : -d_reg[2];
        end
        else if ((ax > ay) && (ax > az))
        begin
            sel_face = (d_reg[0] > 0) ? FACE_POS_X : FACE_NEG_X;
            sel_u    = (d_reg[0] > 0) ? d_reg[2] : -d_reg[2];
            sel_v    = d_reg[1];
        end
        else if ((az > ax) && (az > ay))
        begin
            sel_face = (d_reg[2] > 0) ? FACE_POS_Z : FACE_NEG_Z;
            sel_u    = (d_reg[2] > 0) ? -d_reg[0] : d_reg[0];
            sel_v    = d_reg[1];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == REQ_FRAGMENT)
                        state_next = ST_WMUL;
                    else if (vertex_slot != 2'd3)
                        state_next = ST_RDIV;
                end
            end
            ST_RDIV:
            begin
                if (cnt_reg == CNT_W'(RECIP_STEPS - 1))
                    state_next = ST_IDLE;
            end
            ST_WMUL:
            begin
                if (idx_reg == 2'd3)
                    state_next = ST_NORM;
            end
            ST_NORM:
            begin
                state_next = (sum_reg == '0) ? ST_FACE : ST_RESUM;
            end
            ST_RESUM:
            begin
                state_next = ST_DMUL;
            end
            ST_DMUL:
            begin
                if (idx_reg == 2'd3)
                    state_next = ST_FDIV;
            end
            ST_FDIV:
            begin
                if (cnt_reg == CNT_W'(QUOT_STEPS - 1))
                    state_next = (comp_reg == 2'd2) ? ST_FACE : ST_DMUL;
            end
            ST_FACE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready = 1'b0;
        out_load = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_WMUL:
            begin
                mul_a = $signed({1'b0, bary_reg[idx_rd]});
                mul_b = MULB_W'(vrcp_reg[idx_rd]);
            end
            ST_DMUL:
            begin
                mul_a = MULA_W'($signed(vdir_reg[idx_rd][DIR_W*comp_reg +: DIR_W]));
                mul_b = w_reg[idx_rd][MULB_W-1:0];
            end
            ST_FACE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        ld_slot_next   = ld_slot_reg;
        ld_dir_next    = ld_dir_reg;
        bary_next      = bary_reg;
        vdir_next      = vdir_reg;
        vrcp_next      = vrcp_reg;
        w_next         = w_reg;
        sum_next       = sum_reg;
        num_next       = num_reg;
        neg_next       = neg_reg;
        idx_next       = idx_reg;
        comp_next      = comp_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        dnd_next       = dnd_reg;
        quo_next       = quo_reg;
        d_next         = d_reg;
        degen_next     = degen_reg;
        face_next      = face_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        odeg_next      = odeg_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == REQ_FRAGMENT)
                    begin
                        bary_next[0] = bary_0;
                        bary_next[1] = bary_1;
                        bary_next[2] = bary_2;
                        idx_next     = '0;
                        sum_next     = '0;
                        degen_next   = 1'b0;
                    end
                    else
                    begin
                        ld_slot_next = vertex_slot;
                        ld_dir_next  = {dir_z, dir_y, dir_x};
                        rem_next     = '0;
                        dvs_next     = NORM_W'(clip_w);
                        dnd_next     = RECIP_DND;
                        quo_next     = '0;
                        cnt_next     = '0;
                    end
                end
            end
            ST_RDIV:
            begin
                rem_next = step_rem;
                quo_next = step_quo;
                dnd_next = dnd_reg << 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(RECIP_STEPS - 1))
                begin
                    // 2^32 / 1 and divide-by-zero both saturate
                    vrcp_next[ld_slot_reg] = step_quo[QUO_W-1] ? '1 : step_quo[RCP_W-1:0];
                    vdir_next[ld_slot_reg] = ld_dir_reg;
                end
            end
            ST_WMUL:
            begin
                if (idx_reg != 2'd0)
                begin
                    w_next[idx_prev] = prod_reg[WGT_W-1:0];
                    sum_next         = sum_reg + SUM_W'(prod_reg[WGT_W-1:0]);
                end
                idx_next = idx_reg + 2'd1;
            end
            ST_NORM:
            begin
                if (sum_reg == '0)
                begin
                    degen_next = 1'b1;
                    for (int i = 0; i < 3; i++)
                        d_next[i] = '0;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                        w_next[i] = w_reg[i] >> norm_k;
                end
            end
            ST_RESUM:
            begin
                sum_next  = SUM_W'(w_reg[0]) + SUM_W'(w_reg[1]) + SUM_W'(w_reg[2]);
                idx_next  = '0;
                comp_next = '0;
                num_next  = '0;
            end
            ST_DMUL:
            begin
                if (idx_reg != 2'd0)
                    num_next = num_sum;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    // quotient stays below 2^16, so the top part starts as remainder
                    rem_next = num_mag[NORM_W+QUOT_STEPS-1:QUOT_STEPS];
                    dnd_next = {num_mag[QUOT_STEPS-1:0], {(DND_W-QUOT_STEPS){1'b0}}};
                    neg_next = num_sum[NUM_W-1];
                    quo_next = '0;
                    cnt_next = '0;
                    dvs_next = sum_reg[NORM_W-1:0];
                end
            end
            ST_FDIV:
            begin
                rem_next = step_rem;
                quo_next = step_quo;
                dnd_next = dnd_reg << 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QUOT_STEPS - 1))
                begin
                    d_next[comp_reg] = neg_reg ? -$signed({1'b0, q_val})
                                               : $signed({1'b0, q_val});
                    comp_next = comp_reg + 2'd1;
                    idx_next  = '0;
                    num_next  = '0;
                end
            end
            ST_FACE:
            begin
                if (out_load)
                begin
                    face_next      = sel_face;
                    u_next         = to_coord(sel_u);
                    v_next         = to_coord(sel_v);
                    odeg_next      = degen_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                vdir_reg[i] <= '0;
                vrcp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            vdir_reg      <= vdir_next;
            vrcp_reg      <= vrcp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ld_slot_reg <= ld_slot_next;
        ld_dir_reg  <= ld_dir_next;
        bary_reg    <= bary_next;
        w_reg       <= w_next;
        sum_reg     <= sum_next;
        prod_reg    <= prod_next;
        num_reg     <= num_next;
        neg_reg     <= neg_next;
        idx_reg     <= idx_next;
        comp_reg    <= comp_next;
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        dnd_reg     <= dnd_next;
        quo_reg     <= quo_next;
        d_reg       <= d_next;
        degen_reg   <= degen_next;
        face_reg    <= face_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        odeg_reg    <= odeg_next;
    end

    assign out_valid  = out_valid_reg;
    assign face       = face_reg;
    assign u_coord    = u_reg;
    assign v_coord    = v_reg;
    assign degenerate = odeg_reg;

    `CDFS_ASSERT_NOW(a_degen_center, clk, rst_n,
        out_valid && degenerate,
        (face == FACE_POS_Y) && (u_coord == 16'h8000) && (v_coord == 16'h8000),
        "degenerate result not at face center")

    `CDFS_ASSERT_NOW(a_face_range, clk, rst_n,
        out_valid,
        (face != 3'd6) && (face != 3'd7),
        "face index out of range")

    `CDFS_ASSERT_NEXT(a_frag_busy, clk, rst_n,
        in_valid && in_ready && (req_type == REQ_FRAGMENT),
        !in_ready,
        "request taken while a fragment is in progress")

    `CDFS_ASSERT_NOW(a_div_nonzero, clk, rst_n,
        state_reg == ST_FDIV,
        dvs_reg != '0,
        "fragment division by a zero weight sum")

    `CDFS_ASSERT_NOW(a_div_rem, clk, rst_n,
        state_reg == ST_FDIV,
        rem_reg < dvs_reg,
        "divider remainder not below divisor")

endmodule
